// File: rtl/pcspc_pkg.sv
// Package for the per-core and per-session statistics unit.
// Holds sizes, request codes, payload structs and the front-to-back command struct.
package pcspc_pkg;

   localparam int NumCores    = 5;
   localparam int NumSessions = 64;
   localparam int CoreIdxW    = 3;
   localparam int SessIdxW    = 6;
   localparam int SessAddrW   = (NumSessions > 1) ? $clog2(NumSessions) : 1;
   localparam int TimeW       = 48;
   localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      REQ_RECORD    = 2'd0,
      REQ_READ_CORE = 2'd1,
      REQ_READ_SESS = 2'd2,
      REQ_CLEAR     = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [2:0]       core;
      logic [5:0]       session;
      logic [TimeW-1:0] t_queued;
      logic [TimeW-1:0] t_started;
      logic [TimeW-1:0] t_finished;
      logic [31:0]      bytes;
      logic [31:0]      allocated;
      logic             op_ok;
   } req_type;

   typedef struct packed {
      logic               result_status;
      logic [31:0]        count;
      logic [31:0]        failures;
      logic [63:0]        bytes_total;
      logic signed [63:0] latency_sum;
      logic [62:0]        latency_max;
      logic signed [63:0] wait_sum;
      logic [31:0]        integrity_errors;
      logic [31:0]        total_count;
   } rsp_type;

   // Classified command handed from the front part to the back part.
   typedef struct packed {
      req_kind_type kind;
      logic         core_hit;
      logic [2:0]   core;
      logic         sess_hit;
      logic [5:0]   session;
      logic         bad;
      logic         ok;
      logic [31:0]  bytes;
      logic [63:0]  lat;
      logic [63:0]  wait_t;
   } cmd_type;

   typedef struct packed {
      logic [31:0] jobs;
      logic [31:0] fails;
      logic [63:0] byt;
      logic [63:0] lsum;
      logic [63:0] lpeak;
      logic [63:0] wsum;
   } stat_type;

endpackage

// File: rtl/pcspc_front.sv
// Front part: accepts request transactions, checks integrity and classifies them.
// Depends on pcspc_pkg.
module pcspc_front import pcspc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_stall,
   output cmd_type cmd_data
);
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    ts_ok, by_ok;
   logic    take;

   assign req_stall = valid_ff & cmd_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      ts_ok = (req_data.t_finished != '0) && (req_data.t_queued <= req_data.t_started)
              && (req_data.t_started <= req_data.t_finished);
      by_ok = (req_data.bytes != '0) && (req_data.bytes <= req_data.allocated);
      cmd_in.kind     = req_kind_type'(req_data.req_type);
      cmd_in.core_hit = ({1'b0, req_data.core} < 4'(NumCores));
      cmd_in.core     = req_data.core;
      cmd_in.sess_hit = ({1'b0, req_data.session} < 7'(NumSessions));
      cmd_in.session  = req_data.session;
      cmd_in.bad      = ~(ts_ok & by_ok);
      cmd_in.ok       = req_data.op_ok;
      cmd_in.bytes    = req_data.bytes;
      cmd_in.lat      = {16'd0, req_data.t_finished} - {16'd0, req_data.t_queued};
      cmd_in.wait_t   = {16'd0, req_data.t_started} - {16'd0, req_data.t_queued};
      valid_in        = take | (valid_ff & cmd_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;
endmodule

// File: rtl/pcspc_queue.sv
// Two-entry queue between the front and back parts.
// Depends on pcspc_pkg.
module pcspc_queue import pcspc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output cmd_type out_data
);
   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid & ~in_stall;
   assign pop       = out_valid & ~out_stall;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

// File: rtl/pcspc_back.sv
// Back part: updates core and session statistics and forms results.
// Depends on pcspc_pkg. Session table is a memory with a clearing pass.
module pcspc_back import pcspc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_stall,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_RESP
   } state_type;

   state_type state_ff;
   stat_type  core_ff [NumCores];
   stat_type  sess_mem [NumSessions];
   stat_type  sess_rd_ff;
   stat_type  core_rd, core_new, sess_new;
   cmd_type   cmd_ff;
   logic [31:0] bad_ff, total_ff;
   logic [SessAddrW-1:0] clr_ff;
   rsp_type res_ff, res_in, rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_free, rsp_load;
   logic [34:0] tsum;

   function automatic stat_type add_job(stat_type s, cmd_type c);
      stat_type r;
      r       = s;
      r.jobs  = (s.jobs == CntMax) ? s.jobs : s.jobs + 32'd1;
      r.fails = (~c.ok && s.fails != CntMax) ? s.fails + 32'd1 : s.fails;
      r.byt   = s.byt + {32'd0, c.bytes};
      r.lsum  = s.lsum + c.lat;
      if (!c.lat[63] && c.lat > s.lpeak) r.lpeak = c.lat;
      r.wsum  = s.wsum + c.wait_t;
      return r;
   endfunction

   always_comb begin
      core_rd  = cmd_ff.core_hit ? core_ff[cmd_ff.core[CoreIdxW-1:0]] : '0;
      core_new = add_job(core_rd, cmd_ff);
      sess_new = add_job(sess_rd_ff, cmd_ff);
      tsum = '0;
      for (int i = 0; i < NumCores; i++) begin
         tsum = tsum + {3'd0, core_ff[i].jobs};
      end
   end

   // Data fields of the result, captured in the update step.
   always_comb begin
      res_in = '0;
      case (cmd_ff.kind)
         REQ_RECORD: begin
            res_in.result_status = cmd_ff.bad;
         end
         REQ_READ_CORE: begin
            res_in.count       = core_rd.jobs;
            res_in.failures    = core_rd.fails;
            res_in.bytes_total = core_rd.byt;
            res_in.latency_sum = core_rd.lsum;
            res_in.latency_max = core_rd.lpeak[62:0];
            res_in.wait_sum    = core_rd.wsum;
         end
         REQ_READ_SESS: begin
            if (cmd_ff.sess_hit) begin
               res_in.count       = sess_rd_ff.jobs;
               res_in.failures    = sess_rd_ff.fails;
               res_in.bytes_total = sess_rd_ff.byt;
               res_in.latency_sum = sess_rd_ff.lsum;
               res_in.latency_max = sess_rd_ff.lpeak[62:0];
               res_in.wait_sum    = sess_rd_ff.wsum;
            end
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   // Totals reflect the update made in the update step.
   always_comb begin
      rsp_in = res_ff;
      rsp_in.integrity_errors = bad_ff;
      rsp_in.total_count = (tsum > 35'(CntMax)) ? CntMax : tsum[31:0];
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_RESP) && rsp_free;
   assign cmd_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         bad_ff       <= '0;
         total_ff     <= '0;
         for (int i = 0; i < NumCores; i++) core_ff[i] <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (clr_ff == SessAddrW'(NumSessions - 1)) state_ff <= ST_IDLE;
               clr_ff <= clr_ff + 1'b1;
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd_data;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               // Session entry was read last cycle; apply the command now.
               res_ff   <= res_in;
               state_ff <= ST_RESP;
               case (cmd_ff.kind)
                  REQ_RECORD: begin
                     if (cmd_ff.bad && bad_ff != CntMax) bad_ff <= bad_ff + 32'd1;
                     if (cmd_ff.core_hit) core_ff[cmd_ff.core[CoreIdxW-1:0]] <= core_new;
                  end
                  REQ_READ_CORE: begin
                  end
                  REQ_READ_SESS: begin
                  end
                  default: begin
                     bad_ff <= '0;
                     for (int i = 0; i < NumCores; i++) core_ff[i] <= '0;
                     clr_ff   <= '0;
                  end
               endcase
            end
            ST_RESP: begin
               // Waits here only while the previous result is still stalled.
               if (rsp_free) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= (cmd_ff.kind == REQ_CLEAR) ? ST_CLEAR : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Session memory: one read and one write port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         sess_mem[clr_ff] <= '0;
      end else if (state_ff == ST_UPDATE && cmd_ff.kind == REQ_RECORD && cmd_ff.sess_hit) begin
         sess_mem[cmd_ff.session[SessAddrW-1:0]] <= sess_new;
      end
      sess_rd_ff <= sess_mem[cmd_data.session[SessAddrW-1:0]];
   end
endmodule

// File: rtl/per_core_session_perf_counters.sv
// Top level of the per-core and per-session statistics unit.
// Depends on pcspc_pkg, pcspc_front, pcspc_queue and pcspc_back.
//
// Each request transaction gives one result transaction. A record request checks
// timestamp order and byte bounds, counts integrity errors and adds the job to its
// core (when the index is below the core count) and to its session. Reads return
// one core's or session's statistics plus the error count and the saturating total
// of core job counts; clear zeroes everything. The front part classifies requests
// and computes latency and wait; a two-entry queue decouples it from the back part.
// The back part handles one transaction at a time in its steps (session memory read,
// update, result) and takes no new transaction until the result step is done. A result
// that waits on a stalled output holds the back part in its result step only. After
// reset and after each clear the back part sweeps the 64-entry session memory, one
// entry a cycle, before it takes the next transaction.
module per_core_session_perf_counters import pcspc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   logic    f_valid, f_stall, q_valid, q_stall;
   cmd_type f_cmd, q_cmd;

   pcspc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_data(f_cmd)
   );

   pcspc_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_cmd),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_cmd)
   );

   pcspc_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd_data(q_cmd),
      .rsp_valid, .rsp_stall, .rsp_data
   );

`ifndef SYNTHESIS
   // A record never reports data fields.
   a_rec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_status |-> rsp_data.count == '0)
      else $error("status set with nonzero count");
   // A queued command stays offered until the back part takes it.
   a_q_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_stall |=> q_valid)
      else $error("queue output dropped while stalled");
   // A stalled result stays.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
`endif
endmodule

// File: tb/per_core_session_perf_counters_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the per-core and per-session statistics unit.
// Depends on pcspc_pkg and the per_core_session_perf_counters RTL.
module per_core_session_perf_counters_tb;
   import pcspc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   per_core_session_perf_counters dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Statistics mirror kept by the testbench. Index NumCores and NumSessions
   // are never touched; out-of-range reads are handled explicitly.
   logic [31:0] m_cjobs  [NumCores];
   logic [31:0] m_cfails [NumCores];
   logic [63:0] m_cbytes [NumCores];
   logic [63:0] m_clsum  [NumCores];
   logic [63:0] m_cpeak  [NumCores];
   logic [63:0] m_cwait  [NumCores];
   logic [31:0] m_sjobs  [NumSessions];
   logic [31:0] m_sfails [NumSessions];
   logic [63:0] m_sbytes [NumSessions];
   logic [63:0] m_slsum  [NumSessions];
   logic [63:0] m_speak  [NumSessions];
   logic [63:0] m_swait  [NumSessions];
   logic [31:0] m_bad;

   rsp_type expected_rsps[$];
   int      error_count = 0;
   int      rsp_seen = 0;
   int      records_sent = 0;
   int      reads_sent = 0;
   int      clears_sent = 0;
   longint  cycle_count = 0;

   function automatic logic [31:0] sat_bump(logic [31:0] v);
      return (v == CntMax) ? v : v + 32'd1;
   endfunction

   function automatic void clear_mirror();
      for (int i = 0; i < NumCores; i++) begin
         m_cjobs[i] = '0; m_cfails[i] = '0; m_cbytes[i] = '0;
         m_clsum[i] = '0; m_cpeak[i] = '0; m_cwait[i] = '0;
      end
      for (int i = 0; i < NumSessions; i++) begin
         m_sjobs[i] = '0; m_sfails[i] = '0; m_sbytes[i] = '0;
         m_slsum[i] = '0; m_speak[i] = '0; m_swait[i] = '0;
      end
      m_bad = '0;
   endfunction

   // Applies one request to the mirror and returns the result it should give.
   function automatic rsp_type predict_stats(req_type r);
      rsp_type     o;
      logic [63:0] lat, wt;
      logic        good;
      logic [34:0] tot;
      o = '0;
      case (req_kind_type'(r.req_type))
         REQ_RECORD: begin
            good = (r.t_finished != 0) && (r.t_queued <= r.t_started) &&
                   (r.t_started <= r.t_finished) && (r.bytes != 0) &&
                   (r.bytes <= r.allocated);
            lat = {16'd0, r.t_finished} - {16'd0, r.t_queued};
            wt  = {16'd0, r.t_started} - {16'd0, r.t_queued};
            if (!good) begin
               m_bad = sat_bump(m_bad);
               o.result_status = 1'b1;
            end
            if (r.core < NumCores) begin
               m_cjobs[r.core] = sat_bump(m_cjobs[r.core]);
               if (!r.op_ok) m_cfails[r.core] = sat_bump(m_cfails[r.core]);
               m_cbytes[r.core] += {32'd0, r.bytes};
               m_clsum[r.core] += lat;
               if (!lat[63] && lat > m_cpeak[r.core]) m_cpeak[r.core] = lat;
               m_cwait[r.core] += wt;
            end
            if (r.session < NumSessions) begin
               m_sjobs[r.session] = sat_bump(m_sjobs[r.session]);
               if (!r.op_ok) m_sfails[r.session] = sat_bump(m_sfails[r.session]);
               m_sbytes[r.session] += {32'd0, r.bytes};
               m_slsum[r.session] += lat;
               if (!lat[63] && lat > m_speak[r.session]) m_speak[r.session] = lat;
               m_swait[r.session] += wt;
            end
         end
         REQ_READ_CORE: begin
            if (r.core < NumCores) begin
               o.count = m_cjobs[r.core];       o.failures = m_cfails[r.core];
               o.bytes_total = m_cbytes[r.core]; o.latency_sum = m_clsum[r.core];
               o.latency_max = m_cpeak[r.core][62:0];
               o.wait_sum = m_cwait[r.core];
            end
         end
         REQ_READ_SESS: begin
            if (r.session < NumSessions) begin
               o.count = m_sjobs[r.session];       o.failures = m_sfails[r.session];
               o.bytes_total = m_sbytes[r.session]; o.latency_sum = m_slsum[r.session];
               o.latency_max = m_speak[r.session][62:0];
               o.wait_sum = m_swait[r.session];
            end
         end
         default: clear_mirror();
      endcase
      o.integrity_errors = m_bad;
      tot = '0;
      for (int i = 0; i < NumCores; i++) tot += {3'd0, m_cjobs[i]};
      o.total_count = (tot > {3'd0, CntMax}) ? CntMax : tot[31:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0d] mismatch on %s: got %0h, expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   rsp_type predict_stats_last;

   // Random burst and gap pattern for the sender.
   int burst_left = 0;
   task automatic maybe_gap();
      int g;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 20);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Sender: one request per accepted transaction, prediction at acceptance.
   task automatic issue(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_stats_last = predict_stats(r);
      expected_rsps.push_back(predict_stats_last);
      case (req_kind_type'(r.req_type))
         REQ_RECORD: records_sent++;
         REQ_CLEAR:  clears_sent++;
         default:    reads_sent++;
      endcase
   endtask

   // Receiver stall pattern: quiet stretches alternate with random stalling.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (cycle_count[9:8] == 2'd1) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // Result checker: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with no request outstanding", 64'd1, 64'd0);
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_data.result_status !== w.result_status)
               report_mismatch("result_status", rsp_data.result_status, w.result_status);
            if (rsp_data.count !== w.count)
               report_mismatch("count", rsp_data.count, w.count);
            if (rsp_data.failures !== w.failures)
               report_mismatch("failures", rsp_data.failures, w.failures);
            if (rsp_data.bytes_total !== w.bytes_total)
               report_mismatch("bytes_total", rsp_data.bytes_total, w.bytes_total);
            if (rsp_data.latency_sum !== w.latency_sum)
               report_mismatch("latency_sum", rsp_data.latency_sum, w.latency_sum);
            if (rsp_data.latency_max !== w.latency_max)
               report_mismatch("latency_max", rsp_data.latency_max, w.latency_max);
            if (rsp_data.wait_sum !== w.wait_sum)
               report_mismatch("wait_sum", rsp_data.wait_sum, w.wait_sum);
            if (rsp_data.integrity_errors !== w.integrity_errors)
               report_mismatch("integrity_errors", rsp_data.integrity_errors,
                               w.integrity_errors);
            if (rsp_data.total_count !== w.total_count)
               report_mismatch("total_count", rsp_data.total_count, w.total_count);
         end
      end
   end

   // Hang guard: the limit is far above what the session sweep after each clear and
   // the back part's steps for every transaction need.
   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("per_core_session_perf_counters_tb: errors");
         $finish;
      end
   end

   function automatic req_type mk(req_kind_type k, int c, int s, logic [47:0] tq,
                                  logic [47:0] ts, logic [47:0] tf,
                                  logic [31:0] nb, logic [31:0] al, bit ok);
      req_type r;
      r.req_type = k; r.core = c[2:0]; r.session = s[5:0];
      r.t_queued = tq; r.t_started = ts; r.t_finished = tf;
      r.bytes = nb; r.allocated = al; r.op_ok = ok;
      return r;
   endfunction

   function automatic logic [47:0] rnd48();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[47:0];
   endfunction

   // A request with every field random.
   function automatic req_type rnd_req();
      logic [255:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom()};
      return raw[$bits(req_type)-1:0];
   endfunction

   // A well-formed record with random content, or a deliberately broken one.
   function automatic req_type rnd_record(bit broken);
      req_type     r;
      logic [47:0] base, d1, d2;
      r = rnd_req();
      r.req_type = REQ_RECORD;
      if (!broken) begin
         base = ($urandom_range(0, 7) == 0) ? rnd48() >> 1 : {16'd0, $urandom()};
         d1 = ($urandom_range(0, 9) == 0) ? rnd48() >> 2 : 48'($urandom_range(0, 5000));
         d2 = ($urandom_range(0, 9) == 0) ? rnd48() >> 2 : 48'($urandom_range(0, 90000));
         r.t_queued = base; r.t_started = base + d1;
         r.t_finished = base + d1 + d2 + 48'd1;
         r.bytes = ($urandom_range(0, 7) == 0) ? $urandom() | 32'd1 : $urandom_range(1, 65536);
         r.allocated = r.bytes + $urandom_range(0, 4096);
         if (r.allocated < r.bytes) r.allocated = 32'hFFFF_FFFF;
      end
      return r;
   endfunction

   // Directed table: known answers are checked explicitly on top of the
   // predictor, which still tracks every row.
   typedef struct {
      req_type r;
      bit      has_ans;
      rsp_type ans;
   } dir_row_type;

   dir_row_type dir_rows[$];

   task automatic add_row(req_type r, bit has_ans, rsp_type ans);
      dir_row_type d;
      d.r = r; d.has_ans = has_ans; d.ans = ans;
      dir_rows.push_back(d);
   endtask

   initial begin
      rsp_type z, e;
      req_type r;
      int      n;
      int      k;
      clear_mirror();
      z = '0;
      // After reset every read is zero.
      add_row(mk(REQ_READ_CORE, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
      add_row(mk(REQ_READ_SESS, 7, 63, '1, '1, '1, '1, '1, 1), 1, z);
      // Unfinished job: integrity error, status one, counted anyway.
      e = z; e.result_status = 1'b1; e.integrity_errors = 32'd1; e.total_count = 32'd1;
      add_row(mk(REQ_RECORD, 0, 0, 0, 0, 0, 1, 1, 1), 1, e);
      // Clean record with full-range times and bytes.
      add_row(mk(REQ_RECORD, 4, 63, 0, 48'h7FFF_FFFF_FFFF, '1, '1, '1, 0), 0, z);
      // Start before queue, finish before start, zero bytes, bytes over allocation.
      add_row(mk(REQ_RECORD, 1, 5, 100, 50, 200, 10, 10, 1), 0, z);
      add_row(mk(REQ_RECORD, 1, 5, 100, 300, 200, 10, 10, 1), 0, z);
      add_row(mk(REQ_RECORD, 2, 6, 1, 2, 3, 0, 10, 1), 0, z);
      add_row(mk(REQ_RECORD, 2, 6, 1, 2, 3, 11, 10, 0), 0, z);
      // Negative latency: summed, never raises the maximum.
      add_row(mk(REQ_RECORD, 3, 7, '1, 0, 1, 5, 5, 1), 0, z);
      // Core index at or above the core count skips the core update.
      add_row(mk(REQ_RECORD, 5, 8, 0, 1, 2, 1, 1, 1), 0, z);
      add_row(mk(REQ_RECORD, 7, 9, 0, 0, 48'h1, 1, 1, 0), 0, z);
      for (int c = 0; c < 8; c++) add_row(mk(REQ_READ_CORE, c, 0, 0, 0, 0, 0, 0, 0), 0, z);
      add_row(mk(REQ_READ_SESS, 0, 7, 0, 0, 0, 0, 0, 0), 0, z);
      add_row(mk(REQ_READ_SESS, 0, 63, 0, 0, 0, 0, 0, 0), 0, z);
      // Clear returns all zeros and the following read is zero again.
      add_row(mk(REQ_CLEAR, 7, 63, '1, '1, '1, '1, '1, 1), 1, z);
      add_row(mk(REQ_READ_CORE, 4, 0, 0, 0, 0, 0, 0, 0), 1, z);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         issue(dir_rows[i].r);
         if (dir_rows[i].has_ans && predict_stats_last !== dir_rows[i].ans)
            report_mismatch($sformatf("directed row %0d known answer", i), 64'd1, 64'd0);
         maybe_gap();
      end

      // Random part: mostly well-formed records on a few sessions so that
      // counts pile up, with reads, broken records and rare clears mixed in.
      n = 0;
      while (n < 1500) begin
         k = $urandom_range(0, 99);
         if (k < 55) begin
            r = rnd_record(1'b0);
         end else if (k < 70) begin
            r = rnd_record(1'b1);
         end else if (k < 84) begin
            r = rnd_req();
            r.req_type = REQ_READ_CORE;
         end else if (k < 99) begin
            r = rnd_req();
            r.req_type = REQ_READ_SESS;
         end else begin
            r = '0;
            r.req_type = REQ_CLEAR;
            r.core = 3'($urandom()); r.session = 6'($urandom());
         end
         // Concentrate most traffic on a handful of sessions.
         if (r.req_type != REQ_CLEAR && $urandom_range(0, 3) != 0)
            r.session = 6'($urandom_range(0, 3));
         issue(r);
         n++;
         maybe_gap();
      end
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d records, %0d reads and %0d clears; %0d results checked.",
               records_sent, reads_sent, clears_sent, rsp_seen);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("per_core_session_perf_counters_tb: clean");
      end else begin
         $display("per_core_session_perf_counters_tb: errors");
      end
      $finish;
   end

endmodule

// File: per_core_session_perf_counters.f
rtl/pcspc_pkg.sv
rtl/pcspc_front.sv
rtl/pcspc_queue.sv
rtl/pcspc_back.sv
rtl/per_core_session_perf_counters.sv
tb/per_core_session_perf_counters_tb.sv
